/* rtl/core/shared_buffer_multi_queue_defines.svh */
// Assertion helpers used by the checker file of the shared buffer queue block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shared buffer queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shared buffer queue check failed");

`endif

/* rtl/core/sbmq_pkg.sv */
package sbmq_pkg;

  localparam int QID_W  = 2;
  localparam int DATA_W = 32;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Packed exactly as the tuser field of the input channel, request kind lowest.
  typedef struct packed {
    logic [QID_W-1:0] queue_id;
    req_t             req_type;
  } cmd_t;

  // Outcome of one request as decided by the control unit.
  typedef struct packed {
    status_t status;
    logic    deq_ok;
  } result_t;

endpackage

/* rtl/core/sbmq_ram.sv */
module sbmq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write to the same entry returns the new word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

/* rtl/core/sbmq_ctrl.sv */
module sbmq_ctrl #(
  parameter int SLOTS  = 64,
  parameter int QUEUES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  sbmq_pkg::cmd_t             cur,
  input  logic [$clog2(SLOTS+1)-1:0] link_rd,
  input  sbmq_pkg::cmd_t             nxt,
  output logic [$clog2(SLOTS)-1:0]   link_raddr,
  output logic [$clog2(SLOTS)-1:0]   data_raddr,
  output logic                       link_we,
  output logic [$clog2(SLOTS)-1:0]   link_waddr,
  output logic [$clog2(SLOTS+1)-1:0] link_wdata,
  output logic                       data_we,
  output logic [$clog2(SLOTS)-1:0]   data_waddr,
  output sbmq_pkg::result_t          result
);

  localparam int LW  = $clog2(SLOTS + 1);
  localparam int AW  = $clog2(SLOTS);
  localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [LW-1:0] NIL  = LW'(SLOTS);
  localparam logic [LW-1:0] LAST = LW'(SLOTS - 1);

  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] fill, fill_next;
  logic [LW-1:0] head [QUEUES];
  logic [LW-1:0] head_next [QUEUES];
  logic [LW-1:0] tail [QUEUES];
  logic [LW-1:0] tail_next [QUEUES];

  logic           cq_ok, nq_ok;
  logic [QIW-1:0] cqi, nqi;
  logic [LW-1:0]  c_head, c_tail;
  logic           fresh;

  assign cq_ok  = 32'(cur.queue_id) < QUEUES;
  assign nq_ok  = 32'(nxt.queue_id) < QUEUES;
  assign cqi    = cq_ok ? QIW'(cur.queue_id) : '0;
  assign nqi    = nq_ok ? QIW'(nxt.queue_id) : '0;
  assign c_head = head[cqi];
  assign c_tail = tail[cqi];
  // Slots at and above the fill mark were never handed out; their link is
  // simply the following slot.
  assign fresh  = (free_head == fill);

  always_comb begin
    free_head_next = free_head;
    fill_next      = fill;
    head_next      = head;
    tail_next      = tail;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    data_we        = 1'b0;
    data_waddr     = AW'(free_head);
    result.status  = sbmq_pkg::ST_OK;
    result.deq_ok  = 1'b0;
    case (cur.req_type)
      sbmq_pkg::REQ_ENQ: begin
        if (!cq_ok || (free_head == NIL)) begin
          result.status = sbmq_pkg::ST_OVERFLOW;
        end else if (fire) begin
          if (fresh) begin
            free_head_next = (free_head == LAST) ? NIL : free_head + LW'(1);
            fill_next      = fill + LW'(1);
          end else begin
            free_head_next = link_rd;
          end
          if (c_head == NIL) begin
            head_next[cqi] = free_head;
          end else begin
            link_we    = 1'b1;
            link_waddr = AW'(c_tail);
            link_wdata = free_head;
          end
          tail_next[cqi] = free_head;
          data_we        = 1'b1;
        end
      end
      sbmq_pkg::REQ_DEQ: begin
        if (!cq_ok || (c_head == NIL)) begin
          result.status = sbmq_pkg::ST_UNDERFLOW;
        end else begin
          result.deq_ok = 1'b1;
          if (fire) begin
            head_next[cqi] = (c_head == c_tail) ? NIL : link_rd;
            link_we        = 1'b1;
            link_waddr     = AW'(c_head);
            link_wdata     = free_head;
            free_head_next = c_head;
          end
        end
      end
      default: begin
        result.status = sbmq_pkg::ST_OK;
      end
    endcase
  end

  // The incoming word reads at addresses taken from the state as it will be
  // after the word now being finished.
  always_comb begin
    data_raddr = AW'(head_next[nqi]);
    if (nxt.req_type == sbmq_pkg::REQ_ENQ) begin
      link_raddr = AW'(free_head_next);
    end else begin
      link_raddr = AW'(head_next[nqi]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NIL;
      end
    end else begin
      free_head <= free_head_next;
      fill      <= fill_next;
      head      <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    tail <= tail_next;
  end

endmodule

/* rtl/core/shared_buffer_multi_queue.sv */
// Requests register in the input stage, results in the output stage. Throughput: one request
// per clock unless the master side stalls, enqueue or dequeue in any mix, set by the single
// pass through the control unit with the next-state values forwarded into the RAM reads.
// Reset: synchronous; it clears the handshake stages, the free list head, the fill mark
// and the queue heads at once, so there is no clearing pass and no wait after reset.
module shared_buffer_multi_queue #(
  parameter int SLOTS  = 64,
  parameter int QUEUES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_value[31:0]
  input  logic [2:0]  s_tuser,   // req_type[0], queue_id[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // data_out[31:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);

  // The design is two register stages. The input stage holds the accepted
  // request; the RAM read data for it was fetched at the same edge. The
  // control unit then decides the request and updates the list pointers in
  // one pass, and the answer moves into the output stage. Slots link to each
  // other through the link RAM; free slots form a list whose tail is the run
  // of never used slots above the fill mark.

  logic                    in_valid;
  sbmq_pkg::cmd_t          in_cmd;
  logic [31:0]             in_item;
  logic                    out_valid;
  logic [31:0]             out_data;
  sbmq_pkg::status_t       out_status;

  logic                    fire;
  logic                    accept;
  sbmq_pkg::cmd_t          s_cmd;
  sbmq_pkg::result_t       result;

  logic [LW-1:0]           link_rd;
  logic [31:0]             slot_rd;
  logic [AW-1:0]           link_raddr;
  logic [AW-1:0]           data_raddr;
  logic                    link_we;
  logic [AW-1:0]           link_waddr;
  logic [LW-1:0]           link_wdata;
  logic                    data_we;
  logic [AW-1:0]           data_waddr;

  // The request in the input stage completes whenever the output stage is
  // empty or its word is being taken, so a waiting result never blocks a new
  // word for longer than the consumer stalls.
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!in_valid || fire);
  assign accept   = s_tvalid && s_tready;
  assign s_cmd    = sbmq_pkg::cmd_t'(s_tuser);

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd  <= s_cmd;
      in_item <= s_tdata;
    end
    if (fire) begin
      out_status <= result.status;
      out_data   <= result.deq_ok ? slot_rd : 32'd0;
    end
  end

  sbmq_ctrl #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cur        (in_cmd),
    .link_rd    (link_rd),
    .nxt        (s_cmd),
    .link_raddr (link_raddr),
    .data_raddr (data_raddr),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .result     (result)
  );

  // Link store: the successor of each slot, in its queue or in the free list.
  sbmq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (accept),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  // Data store: the word held in each slot.
  sbmq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (32)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (in_item),
    .re    (accept),
    .raddr (data_raddr),
    .rdata (slot_rd)
  );

endmodule

/* rtl/core/sbmq_checker.sv */
`include "shared_buffer_multi_queue_defines.svh"

module sbmq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result word keeps its contents.
  `SBMQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

  // An overflow or underflow answer carries a zero data word.
  `SBMQ_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != sbmq_pkg::ST_OK), m_tdata == 32'd0)

  // Every accepted request has a result on offer after the input and output stages.
  `SBMQ_ASSERT_NOW(a_result_due, s_tvalid && s_tready, ##2 m_tvalid)

  // A result only appears after a request was accepted.
  `SBMQ_ASSERT_NOW(a_no_phantom, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);
